// ----- design/pcr_pkg.sv -----
// Shared constants, types and helpers for the parallel comb reverb.
// Used by pcr_comb_line, pcr_mix and parallel_comb_reverb; no dependencies.
`default_nettype none

package pcr_pkg;

    // Bank geometry (the line count is a power of two: the average is a shift)
    localparam int NUM_COMBS    = 4;
    localparam int MAX_COMB_LEN = 4096;
    localparam int SAMPLE_BITS  = 16;
    localparam int AVG_SHIFT    = $clog2(NUM_COMBS);

    // Derived widths
    localparam int ADDR_W    = $clog2(MAX_COMB_LEN);
    localparam int LEN_W     = ADDR_W + 1;
    localparam int LEN_CFG_W = 13;
    localparam int CMP_W     = (LEN_W > LEN_CFG_W) ? LEN_W : LEN_CFG_W;
    localparam int FB_W      = 15;
    localparam int W_W       = 16;
    localparam int FRAC_W    = 15;
    localparam int PROD_W    = SAMPLE_BITS + FB_W + 1;
    localparam int MIX_W     = SAMPLE_BITS + W_W + 2;
    localparam int SUM_W     = SAMPLE_BITS + AVG_SHIFT;
    localparam int SAT_W     = 2 * SAMPLE_BITS + 8;
    localparam int ROUND_HALF = 16384;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_LENS   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_A    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_B    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_C    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_D    = 3'd5;

    localparam logic [FB_W-1:0]      FEEDBACK_RST = 15'd27590;
    localparam logic [W_W-1:0]       WET_MIX_RST  = 16'd16384;
    localparam logic [W_W-1:0]       Q_ONE        = 16'd32768;
    localparam logic [LEN_CFG_W-1:0] LEN_A_RST    = 13'd1425;
    localparam logic [LEN_CFG_W-1:0] LEN_B_RST    = 13'd1780;
    localparam logic [LEN_CFG_W-1:0] LEN_C_RST    = 13'd1972;
    localparam logic [LEN_CFG_W-1:0] LEN_D_RST    = 13'd2097;

    // Per-line control from the top level
    typedef struct packed {
        logic                          issue;   // read the line at its position
        logic                          retire;  // write back the stage-1 beat
        logic signed [SAMPLE_BITS-1:0] sample;  // dry sample of the stage-1 beat
    } line_ctl_t;

    // Clamp a wide signed value to the sample range
    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [SAT_W-1:0] v
    );
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = {{(SAT_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
        begin
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        else if (v < lo)
        begin
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/pcr_comb_line.sv -----
// One feedback comb line: delay memory, position and fill count, forwarding.
// Depends on pcr_pkg.
`default_nettype none

module pcr_comb_line (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire pcr_pkg::line_ctl_t                     ctl,
    input  wire logic [pcr_pkg::FB_W-1:0]               feedback,
    input  wire logic [pcr_pkg::CMP_W-1:0]              len,
    output logic signed [pcr_pkg::SAMPLE_BITS-1:0]      delayed
);

    logic [pcr_pkg::ADDR_W-1:0]             pos_reg;
    logic [pcr_pkg::ADDR_W-1:0]             pos_next;
    logic [pcr_pkg::ADDR_W-1:0]             addr_reg;
    logic [pcr_pkg::LEN_W-1:0]              fill_reg;
    logic [pcr_pkg::LEN_W-1:0]              fill_next;
    logic                                   live_reg;
    logic                                   fwd_reg;
    logic signed [pcr_pkg::SAMPLE_BITS-1:0] fwd_data_reg;
    logic signed [pcr_pkg::SAMPLE_BITS-1:0] rdata_reg;
    logic signed [pcr_pkg::SAMPLE_BITS-1:0] wdata;
    logic [pcr_pkg::CMP_W-1:0]              len_eff;
    logic [pcr_pkg::CMP_W-1:0]              pos_inc;
    logic signed [pcr_pkg::PROD_W-1:0]      prod;
    logic signed [pcr_pkg::PROD_W-1:0]      prod_rnd;

    logic signed [pcr_pkg::SAMPLE_BITS-1:0] mem [pcr_pkg::MAX_COMB_LEN];

    always_comb
    begin
        if (len == '0)
        begin
            len_eff = pcr_pkg::CMP_W'(1);
        end
        else if (len > pcr_pkg::CMP_W'(pcr_pkg::MAX_COMB_LEN))
        begin
            len_eff = pcr_pkg::CMP_W'(pcr_pkg::MAX_COMB_LEN);
        end
        else
        begin
            len_eff = len;
        end
    end

    assign pos_inc  = pcr_pkg::CMP_W'(pos_reg) + pcr_pkg::CMP_W'(1);
    assign pos_next = (pos_inc >= len_eff) ? '0 : pos_reg + pcr_pkg::ADDR_W'(1);

    // Entries below the fill count have been written since reset; the
    // position never runs ahead of it, so the count grows by one at most.
    assign fill_next = (pcr_pkg::LEN_W'(pos_reg) == fill_reg)
                     ? fill_reg + pcr_pkg::LEN_W'(1) : fill_reg;

    // A read that meets the write of the beat ahead takes the written value
    assign delayed = fwd_reg ? fwd_data_reg : (live_reg ? rdata_reg : '0);

    assign prod     = pcr_pkg::PROD_W'(delayed)
                    * pcr_pkg::PROD_W'($signed({1'b0, feedback}));
    assign prod_rnd = (prod + pcr_pkg::PROD_W'(pcr_pkg::ROUND_HALF)) >>> pcr_pkg::FRAC_W;
    assign wdata    = pcr_pkg::sat_sample(pcr_pkg::SAT_W'(ctl.sample)
                                        + pcr_pkg::SAT_W'(prod_rnd));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            fill_reg <= '0;
            live_reg <= 1'b0;
            fwd_reg  <= 1'b0;
        end
        else if (ctl.issue)
        begin
            pos_reg  <= pos_next;
            fill_reg <= fill_next;
            live_reg <= (pcr_pkg::LEN_W'(pos_reg) < fill_reg);
            fwd_reg  <= ctl.retire && (addr_reg == pos_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.issue)
        begin
            addr_reg     <= pos_reg;
            fwd_data_reg <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.retire)
        begin
            mem[addr_reg] <= wdata;
        end
        if (ctl.issue)
        begin
            rdata_reg <= mem[pos_reg];
        end
    end

    ap_pos_within_fill: assert property (@(posedge clk) disable iff (!rst_n)
        pcr_pkg::LEN_W'(pos_reg) <= fill_reg)
        else $error("comb position ran past the written region");

    ap_fwd_live: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> live_reg)
        else $error("forward taken from an entry never written");

    ap_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> fill_reg >= $past(fill_reg))
        else $error("fill count went backward");

endmodule

`default_nettype wire

// ----- design/pcr_mix.sv -----
// Average of the comb taps and dry/wet blend, with the output register.
// Depends on pcr_pkg.
`default_nettype none

module pcr_mix (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_beat,
    input  wire logic signed [pcr_pkg::SAMPLE_BITS-1:0] sample,
    input  wire logic signed [pcr_pkg::SAMPLE_BITS-1:0] delayed [pcr_pkg::NUM_COMBS],
    input  wire logic [pcr_pkg::W_W-1:0]                wet_mix,
    input  wire logic                                   out_stall,
    output logic                                        free,
    output logic                                        out_valid,
    output logic signed [pcr_pkg::SAMPLE_BITS-1:0]      sample_out
);

    logic                                   s2_valid_reg;
    logic signed [pcr_pkg::SAMPLE_BITS-1:0] wet_reg;
    logic signed [pcr_pkg::SAMPLE_BITS-1:0] dry_reg;
    logic                                   out_valid_reg;
    logic signed [pcr_pkg::SAMPLE_BITS-1:0] sample_out_reg;
    logic signed [pcr_pkg::SUM_W-1:0]       sum;
    logic [pcr_pkg::W_W-1:0]                w_eff;
    logic [pcr_pkg::W_W-1:0]                w_dry;
    logic signed [pcr_pkg::MIX_W-1:0]       mix;
    logic                                   out_free;
    logic                                   s2_adv;

    always_comb
    begin
        sum = '0;
        for (int c = 0; c < pcr_pkg::NUM_COMBS; c++)
        begin
            sum = sum + pcr_pkg::SUM_W'(delayed[c]);
        end
    end

    assign w_eff = (wet_mix > pcr_pkg::Q_ONE) ? pcr_pkg::Q_ONE : wet_mix;
    assign w_dry = pcr_pkg::Q_ONE - w_eff;

    assign mix = pcr_pkg::MIX_W'(dry_reg) * pcr_pkg::MIX_W'($signed({1'b0, w_dry}))
               + pcr_pkg::MIX_W'(wet_reg) * pcr_pkg::MIX_W'($signed({1'b0, w_eff}))
               + pcr_pkg::MIX_W'(pcr_pkg::ROUND_HALF);

    assign out_free = !out_valid_reg || !out_stall;
    assign s2_adv   = s2_valid_reg && out_free;
    assign free     = !s2_valid_reg || out_free;

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_beat)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            // floor average of the taps
            wet_reg <= pcr_pkg::SAMPLE_BITS'(sum >>> pcr_pkg::AVG_SHIFT);
            dry_reg <= sample;
        end
        if (s2_adv)
        begin
            sample_out_reg <= pcr_pkg::sat_sample(
                pcr_pkg::SAT_W'(mix >>> pcr_pkg::FRAC_W));
        end
    end

endmodule

`default_nettype wire

// ----- design/parallel_comb_reverb.sv -----
// Top level of the parallel comb reverb: configuration registers, stage-1
// handshake, the bank of comb lines and the mix stage.
// Depends on pcr_pkg, pcr_comb_line and pcr_mix.

// One sample per clock sustained while out_stall is low; an accepted beat goes
// through line memory read, tap average and blend on its way to sample_out. The
// rate is set by each comb line's memory, which does one read and one
// write-back per cycle; a read that meets the write-back of the beat ahead at
// the same entry is forwarded. The delay memories need no clearing pass after
// reset: each line keeps a fill count, and entries not below it read as zero.
// Write configuration only while no beat is in flight.
`default_nettype none

module parallel_comb_reverb (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic signed [pcr_pkg::SAMPLE_BITS-1:0] sample_in,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed [pcr_pkg::SAMPLE_BITS-1:0]      sample_out,
    input  wire logic                                   cfg_we,
    input  wire logic [pcr_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [pcr_pkg::CFG_DATA_W-1:0]         cfg_data
);

    logic [pcr_pkg::FB_W-1:0]               comb_feedback_reg;
    logic [pcr_pkg::W_W-1:0]                wet_mix_reg;
    logic [pcr_pkg::LEN_CFG_W-1:0]          comb_len_reg [pcr_pkg::CFG_LENS];
    logic                                   s1_valid_reg;
    logic signed [pcr_pkg::SAMPLE_BITS-1:0] sample_s1_reg;
    logic                                   accept;
    logic                                   mix_free;
    logic                                   s1_adv;
    pcr_pkg::line_ctl_t                     line_ctl;
    logic signed [pcr_pkg::SAMPLE_BITS-1:0] delayed [pcr_pkg::NUM_COMBS];

    assign in_stall = s1_valid_reg && !mix_free;
    assign accept   = in_valid && !in_stall;
    assign s1_adv   = s1_valid_reg && mix_free;

    assign line_ctl.issue  = accept;
    assign line_ctl.retire = s1_adv;
    assign line_ctl.sample = sample_s1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comb_feedback_reg <= pcr_pkg::FEEDBACK_RST;
            wet_mix_reg       <= pcr_pkg::WET_MIX_RST;
            comb_len_reg[0]   <= pcr_pkg::LEN_A_RST;
            comb_len_reg[1]   <= pcr_pkg::LEN_B_RST;
            comb_len_reg[2]   <= pcr_pkg::LEN_C_RST;
            comb_len_reg[3]   <= pcr_pkg::LEN_D_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pcr_pkg::CFG_FEEDBACK: comb_feedback_reg <= cfg_data[pcr_pkg::FB_W-1:0];
                pcr_pkg::CFG_WET_MIX:  wet_mix_reg <= cfg_data[pcr_pkg::W_W-1:0];
                pcr_pkg::CFG_LEN_A:    comb_len_reg[0] <= cfg_data[pcr_pkg::LEN_CFG_W-1:0];
                pcr_pkg::CFG_LEN_B:    comb_len_reg[1] <= cfg_data[pcr_pkg::LEN_CFG_W-1:0];
                pcr_pkg::CFG_LEN_C:    comb_len_reg[2] <= cfg_data[pcr_pkg::LEN_CFG_W-1:0];
                pcr_pkg::CFG_LEN_D:    comb_len_reg[3] <= cfg_data[pcr_pkg::LEN_CFG_W-1:0];
                default:               ; // drop writes to unknown indexes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_s1_reg <= sample_in;
        end
    end

    for (genvar c = 0; c < pcr_pkg::NUM_COMBS; c++)
    begin : g_line
        logic [pcr_pkg::CMP_W-1:0] line_len;

        if (c < pcr_pkg::CFG_LENS)
        begin : g_cfg_len
            assign line_len = pcr_pkg::CMP_W'(comb_len_reg[c]);
        end
        else
        begin : g_fixed_len
            assign line_len = pcr_pkg::CMP_W'(pcr_pkg::MAX_COMB_LEN);
        end

        pcr_comb_line u_line (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (line_ctl),
            .feedback (comb_feedback_reg),
            .len      (line_len),
            .delayed  (delayed[c])
        );
    end

    pcr_mix u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_beat    (s1_adv),
        .sample     (sample_s1_reg),
        .delayed    (delayed),
        .wet_mix    (wet_mix_reg),
        .out_stall  (out_stall),
        .free       (mix_free),
        .out_valid  (out_valid),
        .sample_out (sample_out)
    );

endmodule

`default_nettype wire

// ----- verif/pcr_checker.sv -----
// Scoreboard for parallel_comb_reverb: tracks register writes, predicts each output
// sample from the accepted input beats and compares it with the block's result beats.
// Depends on pcr_pkg for widths, register indexes and reset values.
module pcr_checker (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    input  wire logic                                   in_stall,
    input  wire logic signed [pcr_pkg::SAMPLE_BITS-1:0] sample_in,
    input  wire logic                                   out_valid,
    input  wire logic                                   out_stall,
    input  wire logic signed [pcr_pkg::SAMPLE_BITS-1:0] sample_out,
    input  wire logic                                   cfg_we,
    input  wire logic [pcr_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [pcr_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  wire logic                                   wrap_up,
    output int                                          results_seen,
    output int                                          failures
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint PEAK       = longint'(2 ** (pcr_pkg::SAMPLE_BITS - 1) - 1);
    localparam longint UNITY      = longint'(pcr_pkg::Q_ONE);
    localparam int     REPORT_CAP = 200;

    logic signed [pcr_pkg::SAMPLE_BITS-1:0] echo_mem [pcr_pkg::NUM_COMBS * pcr_pkg::MAX_COMB_LEN];
    int                                     tap_pos [pcr_pkg::NUM_COMBS];
    int                                     tap_len [pcr_pkg::NUM_COMBS];
    int                                     feedback_gain;
    int                                     wet_gain;
    logic signed [pcr_pkg::SAMPLE_BITS-1:0] due_samples [$];
    int                                     seen_count;
    int                                     miss_count;
    bit                                     wrapped;

    function automatic logic signed [pcr_pkg::SAMPLE_BITS-1:0] clamp_sample(input longint v);
        if (v > PEAK)
        begin
            v = PEAK;
        end
        else if (v < -PEAK - 1)
        begin
            v = -PEAK - 1;
        end
        return v[pcr_pkg::SAMPLE_BITS-1:0];
    endfunction

    // Run one dry sample through the comb bank and the dry/wet blend
    function automatic logic signed [pcr_pkg::SAMPLE_BITS-1:0] reverb_step(
        input logic signed [pcr_pkg::SAMPLE_BITS-1:0] dry
    );
        longint x;
        longint tap;
        longint fed;
        longint taps_sum;
        longint wet_avg;
        longint w;
        longint mix;
        int     c;
        int     len;
        int     pos;
        int     slot;
        x = longint'(dry);
        taps_sum = 0;
        for (c = 0; c < pcr_pkg::NUM_COMBS; c++)
        begin
            len = tap_len[c];
            if (len == 0)
            begin
                len = 1;
            end
            if (len > pcr_pkg::MAX_COMB_LEN)
            begin
                len = pcr_pkg::MAX_COMB_LEN;
            end
            pos = tap_pos[c];
            if (pos >= pcr_pkg::MAX_COMB_LEN)
            begin
                pos = pcr_pkg::MAX_COMB_LEN - 1;
            end
            slot = c * pcr_pkg::MAX_COMB_LEN + pos;
            tap = longint'(echo_mem[slot]);
            fed = (tap * longint'(feedback_gain) + longint'(pcr_pkg::ROUND_HALF))
                  >>> pcr_pkg::FRAC_W;
            echo_mem[slot] = clamp_sample(x + fed);
            taps_sum += tap;
            // wrap as soon as the next position reaches a possibly shortened length
            tap_pos[c] = (pos + 1 >= len) ? 0 : pos + 1;
        end
        wet_avg = taps_sum >>> pcr_pkg::AVG_SHIFT;
        w = (longint'(wet_gain) > UNITY) ? UNITY : longint'(wet_gain);
        mix = (x * (UNITY - w) + wet_avg * w + longint'(pcr_pkg::ROUND_HALF))
              >>> pcr_pkg::FRAC_W;
        return clamp_sample(mix);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [pcr_pkg::SAMPLE_BITS-1:0] expected;
        if (!rst_n)
        begin
            foreach (echo_mem[i])
            begin
                echo_mem[i] = '0;
            end
            foreach (tap_pos[i])
            begin
                tap_pos[i] = 0;
            end
            tap_len[0] = int'(pcr_pkg::LEN_A_RST);
            tap_len[1] = int'(pcr_pkg::LEN_B_RST);
            tap_len[2] = int'(pcr_pkg::LEN_C_RST);
            tap_len[3] = int'(pcr_pkg::LEN_D_RST);
            feedback_gain = int'(pcr_pkg::FEEDBACK_RST);
            wet_gain = int'(pcr_pkg::WET_MIX_RST);
            due_samples.delete();
            seen_count = 0;
            miss_count = 0;
            wrapped = 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pcr_pkg::CFG_FEEDBACK: feedback_gain = int'(cfg_data[pcr_pkg::FB_W-1:0]);
                    pcr_pkg::CFG_WET_MIX:  wet_gain = int'(cfg_data[pcr_pkg::W_W-1:0]);
                    pcr_pkg::CFG_LEN_A:    tap_len[0] = int'(cfg_data[pcr_pkg::LEN_CFG_W-1:0]);
                    pcr_pkg::CFG_LEN_B:    tap_len[1] = int'(cfg_data[pcr_pkg::LEN_CFG_W-1:0]);
                    pcr_pkg::CFG_LEN_C:    tap_len[2] = int'(cfg_data[pcr_pkg::LEN_CFG_W-1:0]);
                    pcr_pkg::CFG_LEN_D:    tap_len[3] = int'(cfg_data[pcr_pkg::LEN_CFG_W-1:0]);
                    default:               ; // drop writes to unused indexes
                endcase
            end
            if (in_valid && !in_stall)
            begin
                due_samples.push_back(reverb_step(sample_in));
            end
            if (out_valid && !out_stall)
            begin
                seen_count++;
                if (due_samples.size() == 0)
                begin
                    miss_count++;
                    if (miss_count <= REPORT_CAP)
                    begin
                        $display("%0t: unexpected output beat %0d: expected none, got %0d",
                                 $time, seen_count, sample_out);
                    end
                end
                else
                begin
                    expected = due_samples.pop_front();
                    if (sample_out !== expected)
                    begin
                        miss_count++;
                        if (miss_count <= REPORT_CAP)
                        begin
                            $display("%0t: sample_out mismatch on beat %0d: expected %0d, got %0d",
                                     $time, seen_count, expected, sample_out);
                        end
                    end
                end
            end
            if (wrap_up && !wrapped)
            begin
                wrapped = 1'b1;
                if (due_samples.size() != 0)
                begin
                    $display("%0t: %0d expected output beats never arrived",
                             $time, due_samples.size());
                    miss_count += due_samples.size();
                end
            end
        end
        results_seen <= seen_count;
        failures <= miss_count;
    end

endmodule

// ----- verif/parallel_comb_reverb_test.sv -----
// Testbench top for parallel_comb_reverb: clock, reset, register settings and
// sample stimulus with random idling; checking is done by pcr_checker.
// Depends on pcr_pkg, parallel_comb_reverb and pcr_checker.
module parallel_comb_reverb_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [pcr_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [pcr_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int WATCHDOG     = 2000;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 128;
    localparam int IDLE_PERCENT = 17;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   in_valid = 1'b0;
    logic                                   in_stall;
    logic signed [pcr_pkg::SAMPLE_BITS-1:0] sample_in = '0;
    logic                                   out_valid;
    logic                                   out_stall = 1'b0;
    logic signed [pcr_pkg::SAMPLE_BITS-1:0] sample_out;
    logic                                   cfg_we = 1'b0;
    logic [pcr_pkg::CFG_IDX_W-1:0]          cfg_index = '0;
    logic [pcr_pkg::CFG_DATA_W-1:0]         cfg_data = '0;
    logic                                   calm = 1'b0;
    logic                                   wrap_up = 1'b0;
    int                                     results_seen;
    int                                     failures;
    int                                     items_sent = 0;
    int                                     settings_used = 0;
    int                                     stuck = 0;

    parallel_comb_reverb dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    pcr_checker check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_in    (sample_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_out   (sample_out),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .wrap_up      (wrap_up),
        .results_seen (results_seen),
        .failures     (failures)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        begin
            stuck <= 0;
        end
        else if (stuck >= WATCHDOG)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG);
            $display("parallel_comb_reverb_test: errors");
            $finish;
        end
        else
        begin
            stuck <= stuck + 1;
        end
    end

    // Offer one beat, with random idle cycles ahead of it; return once it is taken
    task automatic push_sample(input logic signed [pcr_pkg::SAMPLE_BITS-1:0] dry);
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            sample_in <= pcr_pkg::SAMPLE_BITS'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_in <= dry;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic write_reg(input logic [pcr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pcr_pkg::CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [pcr_pkg::CFG_DATA_W-1:0] feedback,
                                  input logic [pcr_pkg::CFG_DATA_W-1:0] wet,
                                  input logic [pcr_pkg::CFG_DATA_W-1:0] len_a,
                                  input logic [pcr_pkg::CFG_DATA_W-1:0] len_b,
                                  input logic [pcr_pkg::CFG_DATA_W-1:0] len_c,
                                  input logic [pcr_pkg::CFG_DATA_W-1:0] len_d);
        write_reg(pcr_pkg::CFG_FEEDBACK, feedback);
        write_reg(pcr_pkg::CFG_WET_MIX, wet);
        write_reg(pcr_pkg::CFG_LEN_A, len_a);
        write_reg(pcr_pkg::CFG_LEN_B, len_b);
        write_reg(pcr_pkg::CFG_LEN_C, len_c);
        write_reg(pcr_pkg::CFG_LEN_D, len_d);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Hold the input until every sent beat has come out, then let the pipe settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (results_seen < items_sent)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic [pcr_pkg::CFG_DATA_W-1:0]         feedback;
        logic [pcr_pkg::CFG_DATA_W-1:0]         wet;
        logic [pcr_pkg::CFG_DATA_W-1:0]         lens [4];
        logic signed [pcr_pkg::SAMPLE_BITS-1:0] dry;
        int                                     phase;
        int                                     k;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: sample extremes through empty delay lines
        push_sample(16'sh7fff);
        push_sample(-16'sh8000);
        push_sample(16'sh0000);
        push_sample(16'sh0001);
        push_sample(-16'sh0001);
        push_sample(16'sh5555);
        push_sample(-16'sh5556);
        push_sample(16'sh7fff);
        push_sample(-16'sh8000);
        wait_drained();

        // short lines with a zero length, full feedback and fully wet: echoes saturate
        apply_settings(16'h7fff, 16'h8000, 16'd1, 16'd2, 16'd0, 16'd3);
        push_sample(16'sh7fff);
        push_sample(16'sh7fff);
        push_sample(16'sh7fff);
        push_sample(16'sh7fff);
        push_sample(-16'sh8000);
        push_sample(-16'sh8000);
        push_sample(-16'sh8000);
        wait_drained();

        // unused indexes, oversize lengths, wet gain above unity, no feedback
        write_reg(CFG_SPARE_LO, 16'hffff);
        write_reg(CFG_SPARE_HI, 16'h1234);
        apply_settings(16'h0000, 16'hffff, 16'h1fff, 16'd4097, 16'd4096, 16'd2);
        push_sample(16'sh7fff);
        push_sample(-16'sh8000);
        push_sample(16'sh3039);
        push_sample(-16'sh0001);
        push_sample(16'sh0000);
        wait_drained();

        // random settings; shorter lines leave positions past the new length
        for (phase = 0; phase < PHASES; phase++)
        begin
            case ($urandom_range(3))
                0:       feedback = 16'h0000;
                1:       feedback = 16'h7fff;
                2:       feedback = pcr_pkg::CFG_DATA_W'($urandom_range(16'hffff));
                default: feedback = pcr_pkg::CFG_DATA_W'(pcr_pkg::FEEDBACK_RST);
            endcase
            case ($urandom_range(3))
                0:       wet = 16'h0000;
                1:       wet = pcr_pkg::Q_ONE;
                2:       wet = pcr_pkg::CFG_DATA_W'($urandom_range(16'hffff, 16'h8001));
                default: wet = pcr_pkg::CFG_DATA_W'($urandom_range(pcr_pkg::Q_ONE));
            endcase
            foreach (lens[i])
            begin
                case ($urandom_range(7))
                    0:       lens[i] = 16'd0;
                    1:       lens[i] = pcr_pkg::CFG_DATA_W'(
                                 $urandom_range(8191, pcr_pkg::MAX_COMB_LEN));
                    2:       lens[i] = pcr_pkg::CFG_DATA_W'($urandom_range(16'hffff));
                    default: lens[i] = pcr_pkg::CFG_DATA_W'($urandom_range(48, 1));
                endcase
            end
            apply_settings(feedback, wet, lens[0], lens[1], lens[2], lens[3]);
            calm <= (phase == 5);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (phase == 3 && k == PHASE_ITEMS / 2)
                begin
                    wait_drained();
                end
                case ($urandom_range(9))
                    6, 7:    dry = $urandom_range(1) ? 16'sh7fff : -16'sh8000;
                    8:       dry = $signed(16'($urandom_range(64))) - 16'sd32;
                    9:       dry = $signed(16'($urandom_range(8191))) - 16'sd4096;
                    default: dry = pcr_pkg::SAMPLE_BITS'($urandom);
                endcase
                push_sample(dry);
            end
            wait_drained();
        end

        wrap_up <= 1'b1;
        repeat (2) @(posedge clk);
        $display("Sent %0d samples under %0d register settings, %0d output beats compared.",
                 items_sent, settings_used, results_seen);
        if (failures == 0)
        begin
            $display("parallel_comb_reverb_test: clean");
        end
        else
        begin
            $display("parallel_comb_reverb_test: errors");
        end
        $finish;
    end

endmodule
